// ----- src/fxalu_pkg.sv -----
package fxalu_pkg;

    localparam int unsigned FracBitsDefault = 14;
    localparam int unsigned WordBits        = 32;
    localparam int unsigned ProdBits        = 64;

    // Opcode codes carried in the kind field.
    typedef enum logic [3:0] {
        K_ITOF       = 4'd0,
        K_FTOI_TRUNC = 4'd1,
        K_FTOI_ROUND = 4'd2,
        K_ADD        = 4'd3,
        K_SUB        = 4'd4,
        K_ADD_INT    = 4'd5,
        K_SUB_INT    = 4'd6,
        K_MUL        = 4'd7,
        K_MUL_INT    = 4'd8,
        K_DIV        = 4'd9,
        K_DIV_INT    = 4'd10
    } t_kind;

    typedef struct packed {
        logic [3:0]         kind;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } t_in;

    typedef struct packed {
        logic signed [31:0] result;
        logic               divide_by_zero;
    } t_out;

    // Operation routing decided at the front of the pipeline.
    typedef struct packed {
        logic is_mul;
        logic is_div;
        logic is_simple;
        logic div_zero;
    } t_route;

endpackage

// ----- src/fxalu_mul.sv -----
// Pipelined signed multiplier built from four 16x16 partial products, plus a
// shift stage that divides by 2^FRAC_BITS truncating toward zero, or keeps the low word.
module fxalu_mul #(
    parameter int unsigned FRAC_BITS = fxalu_pkg::FracBitsDefault
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic signed [31:0] i_a,
    input  logic signed [31:0] i_b,
    input  logic               i_scale,
    output logic               o_valid,
    output logic [31:0]        o_result
);
    logic [1:0]         r_v;
    logic [63:0]        r_ll, r_lh, r_hl;
    logic [31:0]        r_hh_unused_free;
    logic               r_neg1, r_scale1;
    logic [63:0]        r_prod;
    logic               r_scale2;
    logic [31:0]        r_res;
    logic               r_v3;
    logic [31:0]        ua, ub;
    logic [63:0]        n_prod;
    logic signed [63:0] sp;
    logic signed [63:0] sp_adj;

    // Magnitudes split in 16-bit halves; the sign is applied after summing.
    assign ua = i_a[31] ? (~i_a + 32'd1) : i_a;
    assign ub = i_b[31] ? (~i_b + 32'd1) : i_b;

    // Stage 1: partial products of the magnitudes, each 32 bits wide.
    always_ff @(posedge i_clk) begin
        r_ll             <= {32'd0, {16'd0, ua[15:0]} * {16'd0, ub[15:0]}};
        r_lh             <= {32'd0, {16'd0, ua[15:0]} * {16'd0, ub[31:16]}};
        r_hl             <= {32'd0, {16'd0, ua[31:16]} * {16'd0, ub[15:0]}};
        r_hh_unused_free <= {16'd0, ua[31:16]} * {16'd0, ub[31:16]};
        r_neg1           <= i_a[31] ^ i_b[31];
        r_scale1         <= i_scale;
    end

    // Stage 2: sum the partial products and restore the sign.
    assign n_prod = r_ll + (r_lh << 16) + (r_hl << 16) + {r_hh_unused_free, 32'd0};
    always_ff @(posedge i_clk) begin
        r_prod   <= r_neg1 ? (~n_prod + 64'd1) : n_prod;
        r_scale2 <= r_scale1;
    end

    // Stage 3: divide by 2^FRAC_BITS toward zero, or keep the low word.
    assign sp     = $signed(r_prod);
    assign sp_adj = sp + (sp[63] ? ((64'sd1 <<< FRAC_BITS) - 64'sd1) : 64'sd0);
    always_ff @(posedge i_clk) begin
        r_res <= r_scale2 ? 32'(sp_adj >>> FRAC_BITS) : r_prod[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_v3 <= 1'b0;
        end else begin
            r_v  <= {r_v[0], i_valid};
            r_v3 <= r_v[1];
        end
    end

    assign o_valid  = r_v3;
    assign o_result = r_res;
endmodule

// ----- src/fxalu_div.sv -----
// Pipelined restoring divider: one quotient bit per stage over a 64-bit
// dividend magnitude, truncating toward zero.
module fxalu_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic signed [63:0] i_num,
    input  logic signed [31:0] i_den,
    output logic               o_valid,
    output logic [31:0]        o_result
);
    localparam int unsigned Steps = fxalu_pkg::ProdBits;

    logic [Steps:0]    r_v;
    logic [63:0]       r_q   [Steps+1];
    logic [32:0]       r_rem [Steps+1];
    logic [31:0]       r_den [Steps+1];
    logic              r_neg [Steps+1];

    // Stage 0: take magnitudes.
    always_ff @(posedge i_clk) begin
        r_q[0]   <= i_num[63] ? (~i_num + 64'd1) : i_num;
        r_rem[0] <= '0;
        r_den[0] <= i_den[31] ? (~i_den + 32'd1) : i_den;
        r_neg[0] <= i_num[63] ^ i_den[31];
    end

    // One quotient bit per stage; the dividend shifts out as quotient shifts in.
    for (genvar s = 0; s < Steps; s++) begin : g_step
        logic [32:0] trial;
        logic [33:0] diff;
        assign trial = {r_rem[s][31:0], r_q[s][63]};
        assign diff  = {1'b0, trial} - {2'b0, r_den[s]};
        always_ff @(posedge i_clk) begin
            if (!diff[33]) begin
                r_rem[s+1] <= diff[32:0];
                r_q[s+1]   <= {r_q[s][62:0], 1'b1};
            end else begin
                r_rem[s+1] <= trial;
                r_q[s+1]   <= {r_q[s][62:0], 1'b0};
            end
            r_den[s+1] <= r_den[s];
            r_neg[s+1] <= r_neg[s];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[Steps-1:0], i_valid};
        end
    end

    assign o_valid  = r_v[Steps];
    assign o_result = r_neg[Steps] ? (~r_q[Steps][31:0] + 32'd1) : r_q[Steps][31:0];
endmodule

// ----- src/fixed_point_17_14_alu_top.sv -----
// Signed fixed-point ALU with FRAC_BITS fractional bits (17.14 by default).
// One transaction may start in every cycle (busy is always low) and each
// gives exactly one result, in order, marked by o_done for one cycle; the
// receiver cannot stall. Latency is the same for every opcode, set by the
// divider's input stage and its 64 quotient stages: other opcodes are
// delayed to match so results leave in order. A zero divisor gives result 0
// with divide_by_zero set.
module fixed_point_17_14_alu_top #(
    parameter int unsigned FRAC_BITS = fxalu_pkg::FracBitsDefault
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  fxalu_pkg::t_in   i_in,
    output logic             o_done,
    output fxalu_pkg::t_out  o_out
);
    localparam int unsigned Lat = fxalu_pkg::ProdBits;

    logic               take;
    logic [31:0]        a, b, bf, n_simple;
    fxalu_pkg::t_route  n_route;
    logic               mul_v, div_v;
    logic               mul_done, div_done;
    logic [31:0]        mul_res, div_res;
    logic signed [63:0] div_num;
    logic signed [63:0] a_ext, half, fmask;

    logic [Lat:0]       r_v;
    fxalu_pkg::t_route  r_route [Lat+1];
    logic [31:0]        r_simple[Lat+1];
    logic [31:0]        r_mul_hold [Lat-2];

    assign busy = 1'b0;
    assign take = start & ~busy;
    assign a    = i_in.operand_a;
    assign b    = i_in.operand_b;
    assign bf   = b << FRAC_BITS;
    assign a_ext = 64'(signed'(i_in.operand_a));
    assign half  = 64'sd1 <<< (FRAC_BITS - 1);
    assign fmask = (64'sd1 <<< FRAC_BITS) - 64'sd1;

    // Opcodes that need no multiplier or divider are computed here combinationally and carried down the delay line.
    // Negative values are biased by 2^FRAC_BITS-1 so the shift truncates toward zero.
    always_comb begin
        n_simple = '0;
        n_route  = '0;
        case (fxalu_pkg::t_kind'(i_in.kind))
            fxalu_pkg::K_ITOF:       n_simple = bf;
            fxalu_pkg::K_FTOI_TRUNC:
                n_simple = 32'((a_ext + (a[31] ? fmask : 64'sd0)) >>> FRAC_BITS);
            fxalu_pkg::K_FTOI_ROUND: n_simple = a[31]
                ? 32'((a_ext - half + fmask) >>> FRAC_BITS)
                : 32'((a_ext + half) >>> FRAC_BITS);
            fxalu_pkg::K_ADD:        n_simple = a + b;
            fxalu_pkg::K_SUB:        n_simple = a - b;
            fxalu_pkg::K_ADD_INT:    n_simple = a + bf;
            fxalu_pkg::K_SUB_INT:    n_simple = a - bf;
            fxalu_pkg::K_MUL, fxalu_pkg::K_MUL_INT: n_route.is_mul = 1'b1;
            fxalu_pkg::K_DIV, fxalu_pkg::K_DIV_INT: begin
                n_route.is_div   = (b != '0);
                n_route.div_zero = (b == '0);
            end
            default:                 n_simple = '0;
        endcase
        n_route.is_simple = ~n_route.is_mul & ~n_route.is_div;
    end

    assign mul_v   = take & n_route.is_mul;
    assign div_v   = take & n_route.is_div;
    assign div_num = (i_in.kind == fxalu_pkg::K_DIV) ? (a_ext <<< FRAC_BITS) : a_ext;

    fxalu_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .i_clk, .i_rst_n, .i_valid(mul_v), .i_a(a), .i_b(b),
        .i_scale(i_in.kind == fxalu_pkg::K_MUL),
        .o_valid(mul_done), .o_result(mul_res)
    );

    fxalu_div u_div (
        .i_clk, .i_rst_n, .i_valid(div_v), .i_num(div_num), .i_den(b),
        .o_valid(div_done), .o_result(div_res)
    );

    // Delay line that keeps every transaction in order with the divider.
    always_ff @(posedge i_clk) begin
        r_route[0]  <= n_route;
        r_simple[0] <= n_simple;
        for (int i = 0; i < Lat; i++) begin
            r_route[i+1]  <= r_route[i];
            r_simple[i+1] <= r_simple[i];
        end
        r_mul_hold[0] <= mul_res;
        for (int i = 0; i < Lat - 3; i++) r_mul_hold[i+1] <= r_mul_hold[i];
        if (!i_rst_n) r_v <= '0;
        else          r_v <= {r_v[Lat-1:0], take};
    end

    // Output selection; the divider delivers in its last stage combinationally.
    assign o_done = r_v[Lat];
    always_comb begin
        o_out = '0;
        if (r_route[Lat].is_mul)         o_out.result = r_mul_hold[Lat-3];
        else if (r_route[Lat].is_div)    o_out.result = div_res;
        else if (r_route[Lat].is_simple) o_out.result = r_simple[Lat];
        o_out.divide_by_zero = r_route[Lat].div_zero;
    end

    // The routing of a finished transaction selects exactly one source.
    a_route: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $onehot({r_route[Lat].is_mul, r_route[Lat].is_div,
                            r_route[Lat].is_simple}))
        else $error("route not one-hot");
    a_dz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_out.divide_by_zero) |-> (o_out.result == '0))
        else $error("zero divisor with nonzero result");
    a_busy: assert property (@(posedge i_clk) !busy)
        else $error("busy raised");
    // The multiplier result lines up with the third stage of the delay line.
    a_mul_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> (r_v[2] && r_route[2].is_mul))
        else $error("multiplier out of step");
    // The divider result lines up with the end of the delay line.
    a_div_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (o_done && r_route[Lat].is_div))
        else $error("divider out of step");
endmodule
